// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. They compile away when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/aes_ikr_pkg.sv -----
// ----------------------------------------------------------------------------
// AES inverse key round package
// Request types, fixed AES-128 key geometry and the forward S-box.
// ----------------------------------------------------------------------------
package aes_ikr_pkg;

  localparam int unsigned KEY_WORDS      = 4;
  localparam int unsigned BYTES_PER_WORD = 4;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned WORD_W         = BYTES_PER_WORD * BYTE_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    word_t key_word_0;
    word_t key_word_1;
    word_t key_word_2;
    word_t key_word_3;
    byte_t round_constant;
  } aes_ikr_in_t;

  typedef struct packed {
    word_t prev_word_0;
    word_t prev_word_1;
    word_t prev_word_2;
    word_t prev_word_3;
  } aes_ikr_out_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t sub_byte(input byte_t b);
    return SBOX[b];
  endfunction

endpackage

// ----- hw/rtl/aes_ikr_key_core.sv -----
// ----------------------------------------------------------------------------
// AES key schedule core function
// Rotates a word left by one byte, substitutes each byte through the S-box
// and folds the round constant into the row 0 byte.
// ----------------------------------------------------------------------------
module aes_ikr_key_core import aes_ikr_pkg::*; (
  input  word_t word_i,
  input  byte_t rcon_i,
  output word_t word_o
);

  word_t rot;
  word_t sub;

  // Row 1 moves up to row 0, row 0 wraps round to row 3.
  assign rot = {word_i[WORD_W-BYTE_W-1:0], word_i[WORD_W-1 -: BYTE_W]};

  for (genvar b = 0; b < BYTES_PER_WORD; b++) begin : g_sub
    assign sub[b*BYTE_W +: BYTE_W] = sub_byte(rot[b*BYTE_W +: BYTE_W]);
  end

  assign word_o = sub ^ {rcon_i, {(WORD_W-BYTE_W){1'b0}}};

endmodule

// ----- hw/rtl/aes_inverse_key_round.sv -----
// ----------------------------------------------------------------------------
// AES-128 inverse key expansion round
// Each request carries one AES-128 round key as four column words, row 0
// byte in bits 31:24, together with the round constant of the round that
// produced it; the block answers with the previous round key in the same
// byte order. Words 1 to 3 of the answer are the XOR of adjacent key words,
// and word 0 is key word 0 XOR the key schedule function of the new word 3.
// Any round constant byte is accepted and applied as given. The block is a
// two-register pipeline: a request is captured in an input register, the
// XORs and the four S-box lookups run between the two registers, and the
// answer lands in a result register, from which it is presented on the
// output. It takes one request every clock cycle while the output side keeps
// taking answers. The S-box lookup between the two registers is the path
// that sets the clock. Either register stage holds its request when the
// stage after it is stalled, so up to two requests can be in flight, and the
// input side keeps accepting while an answer waits to be taken provided the
// input register is empty. The block keeps no state between requests, and
// reset only empties the pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aes_inverse_key_round import aes_ikr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,

  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  aes_ikr_in_t  in_req_i,

  output logic         out_valid_o,
  input  logic         out_ready_i,
  output aes_ikr_out_t out_req_o
);

  // Input register stage.
  logic         s1_valid_q, s1_valid_d;
  aes_ikr_in_t  s1_req_q;

  // Result register stage.
  logic         out_valid_q, out_valid_d;
  aes_ikr_out_t out_req_q;

  logic         out_ready;
  logic         s1_ready;
  aes_ikr_out_t result_d;
  word_t        prev_word_3;
  word_t        core_word;

  // The result register can load when it is empty or its answer is taken this
  // cycle; the input register can load when it is empty or can pass forward.
  assign out_ready  = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_ready_o = s1_ready;

  assign s1_valid_d  = in_valid_i || (s1_valid_q && !out_ready);
  assign out_valid_d = s1_valid_q || (out_valid_q && !out_ready_i);

  // Previous key words: the three upper ones fall out of adjacent XORs, and
  // word 0 needs the key schedule function of the recovered word 3.
  assign prev_word_3 = s1_req_q.key_word_3 ^ s1_req_q.key_word_2;

  aes_ikr_key_core u_key_core (
    .word_i (prev_word_3),
    .rcon_i (s1_req_q.round_constant),
    .word_o (core_word)
  );

  always_comb begin
    result_d.prev_word_3 = prev_word_3;
    result_d.prev_word_2 = s1_req_q.key_word_2 ^ s1_req_q.key_word_1;
    result_d.prev_word_1 = s1_req_q.key_word_1 ^ s1_req_q.key_word_0;
    result_d.prev_word_0 = s1_req_q.key_word_0 ^ core_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= s1_valid_d;
      end
      if (out_ready) begin
        out_valid_q <= out_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_req_q <= in_req_i;
    end
    if (s1_valid_q && out_ready) begin
      out_req_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // An accepted request always occupies the input register next cycle.
  `ASSERT_NEXT(a_accept_fills_s1, clk_i, rst_ni, in_valid_i && in_ready_o, s1_valid_q)
  // A request that moves forward always yields a valid answer next cycle.
  `ASSERT_NEXT(a_s1_moves_to_out, clk_i, rst_ni, s1_valid_q && out_ready, out_valid_q)
  // The answer loaded is the one computed from the input register.
  `ASSERT_NEXT(a_out_matches, clk_i, rst_ni, s1_valid_q && out_ready, out_req_o == $past(result_d))
  // Back-pressure reaches the input only when both stages are full.
  `ASSERT_IMPLY(a_stall_full, clk_i, rst_ni, !in_ready_o, s1_valid_q && out_valid_q)

endmodule
